FILE: rtl/frustum_cull_tester_core_macros.svh
// Assertion macros used by the checker file.
`ifndef FRUSTUM_CULL_TESTER_CORE_MACROS_SVH
`define FRUSTUM_CULL_TESTER_CORE_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define FCT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define FCT_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Same-cycle implication that also holds across reset.
`define FCT_ASSERT_RST(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: rtl/fct_pkg.sv
package fct_pkg;

   localparam int NumPlanes = 6;
   localparam int NumAxes   = 3;
   localparam int CoordW    = 32;
   localparam int ProdW     = 2 * CoordW;
   localparam int BiasW     = CoordW + 1;
   localparam int FracW     = 16;
   localparam int SumW      = ProdW + 2;
   localparam int PlaneIdxW = 3;
   localparam int FuncW     = 2;
   localparam int ReqDataW  = 7 * CoordW;
   localparam int ReqUserW  = FuncW + PlaneIdxW;
   localparam int RspDataW  = 8;

   typedef enum logic [FuncW-1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_POINT  = 2'd1,
      FUNC_SPHERE = 2'd2,
      FUNC_BOX    = 2'd3
   } func_type;

   typedef logic signed [CoordW-1:0] coord_type;
   typedef logic signed [ProdW-1:0]  prod_type;
   typedef logic signed [BiasW-1:0]  bias_type;
   typedef logic signed [SumW-1:0]   sum_type;

endpackage

FILE: rtl/frustum_cull_tester_core.sv
// Six-plane view-frustum culling tester. A load transfer (func 0) writes the normal and
// offset of one plane; indexes 6 and 7 are dropped. Point, sphere and box tests each return
// one transfer whose inside_res bit is 1 when no plane culls the shape; all arithmetic is exact
// Q16.16 with no rounding or saturation. The block takes one item per cycle while the result side
// is ready, and returns a test result through an input register, a stage of eighteen 32x32
// multipliers (three per plane, one per axis), and a stage that sums each plane with its
// offset and checks the sign. Loads take effect as they leave the input register, so a test
// always sees every load sent ahead of it and none sent after it.
module frustum_cull_tester_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // coord_x, coord_y, coord_z, far_x, far_y, far_z, scalar
   input  logic [fct_pkg::ReqDataW-1:0]   req_tdata,
   // func, plane_index
   input  logic [fct_pkg::ReqUserW-1:0]   req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // inside_res, zero fill
   output logic [fct_pkg::RspDataW-1:0]   rsp_tdata
);
   import fct_pkg::*;

   // input register
   logic                  s1_valid_ff, s1_valid_in;
   func_type              s1_func_ff, s1_func_in;
   logic [PlaneIdxW-1:0]  s1_idx_ff, s1_idx_in;
   coord_type             s1_near_ff [NumAxes];
   coord_type             s1_near_in [NumAxes];
   coord_type             s1_far_ff  [NumAxes];
   coord_type             s1_far_in  [NumAxes];
   coord_type             s1_scalar_ff, s1_scalar_in;

   // plane store
   coord_type             nrm_ff [NumPlanes][NumAxes];
   coord_type             nrm_in [NumPlanes][NumAxes];
   coord_type             ofs_ff [NumPlanes];
   coord_type             ofs_in [NumPlanes];

   // product register
   logic                  s2_valid_ff, s2_valid_in;
   prod_type              prod_ff [NumPlanes][NumAxes];
   prod_type              prod_in [NumPlanes][NumAxes];
   bias_type              bias_ff [NumPlanes];
   bias_type              bias_in [NumPlanes];

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  inside_ff, inside_in;

   logic                  s1_is_load;
   logic                  load_en;
   logic                  s1_free, s2_free, s3_free;
   logic                  s2_load, s3_load;
   coord_type             sel_c;
   coord_type             rad;
   sum_type               sum;
   logic                  pass;

   assign s1_is_load = (s1_func_ff == FUNC_LOAD);
   assign load_en    = s1_valid_ff && s1_is_load;

   // a load in the input register never waits on downstream stages
   assign s3_free = !rsp_valid_ff || rsp_tready;
   assign s2_free = !s2_valid_ff || s3_free;
   assign s1_free = !s1_valid_ff || s1_is_load || s2_free;
   assign req_tready = s1_free;

   assign s2_load = s2_free && s1_valid_ff && !s1_is_load;
   assign s3_load = s3_free && s2_valid_ff;

   always_comb begin
      s1_valid_in  = s1_free ? req_tvalid : s1_valid_ff;
      s1_func_in   = s1_func_ff;
      s1_idx_in    = s1_idx_ff;
      s1_near_in   = s1_near_ff;
      s1_far_in    = s1_far_ff;
      s1_scalar_in = s1_scalar_ff;
      if (req_tvalid && s1_free) begin
         s1_func_in   = func_type'(req_tuser[FuncW-1:0]);
         s1_idx_in    = req_tuser[FuncW +: PlaneIdxW];
         for (int k = 0; k < NumAxes; k++) begin
            s1_near_in[k] = req_tdata[k*CoordW +: CoordW];
            s1_far_in[k]  = req_tdata[(k+NumAxes)*CoordW +: CoordW];
         end
         s1_scalar_in = req_tdata[2*NumAxes*CoordW +: CoordW];
      end
   end

   always_comb begin
      nrm_in = nrm_ff;
      ofs_in = ofs_ff;
      for (int p = 0; p < NumPlanes; p++) begin
         if (load_en && (s1_idx_ff == PlaneIdxW'(p))) begin
            nrm_in[p] = s1_near_ff;
            ofs_in[p] = s1_scalar_ff;
         end
      end
   end

   // box: take the corner coordinate that makes each product largest
   always_comb begin
      s2_valid_in = s2_free ? (s1_valid_ff && !s1_is_load) : s2_valid_ff;
      prod_in     = prod_ff;
      bias_in     = bias_ff;
      rad         = (s1_func_ff == FUNC_SPHERE) ? s1_scalar_ff : '0;
      sel_c       = '0;
      if (s2_load) begin
         for (int p = 0; p < NumPlanes; p++) begin
            for (int k = 0; k < NumAxes; k++) begin
               sel_c = s1_near_ff[k];
               if (s1_func_ff == FUNC_BOX) begin
                  if (nrm_ff[p][k] >= 0) begin
                     sel_c = (s1_far_ff[k] > s1_near_ff[k]) ? s1_far_ff[k] : s1_near_ff[k];
                  end else begin
                     sel_c = (s1_far_ff[k] < s1_near_ff[k]) ? s1_far_ff[k] : s1_near_ff[k];
                  end
               end
               prod_in[p][k] = sel_c * nrm_ff[p][k];
            end
            bias_in[p] = BiasW'(ofs_ff[p]) + BiasW'(rad);
         end
      end
   end

   always_comb begin
      rsp_valid_in = s3_free ? s2_valid_ff : rsp_valid_ff;
      inside_in    = inside_ff;
      pass         = 1'b1;
      sum          = '0;
      for (int p = 0; p < NumPlanes; p++) begin
         sum = (SumW'(bias_ff[p]) <<< FracW) + SumW'(prod_ff[p][0])
             + SumW'(prod_ff[p][1]) + SumW'(prod_ff[p][2]);
         if (sum[SumW-1]) begin
            pass = 1'b0;
         end
      end
      if (s3_load) begin
         inside_in = pass;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < NumPlanes; p++) begin
            for (int k = 0; k < NumAxes; k++) begin
               nrm_ff[p][k] <= '0;
            end
            ofs_ff[p] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         nrm_ff       <= nrm_in;
         ofs_ff       <= ofs_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_func_ff   <= s1_func_in;
      s1_idx_ff    <= s1_idx_in;
      s1_near_ff   <= s1_near_in;
      s1_far_ff    <= s1_far_in;
      s1_scalar_ff <= s1_scalar_in;
      prod_ff      <= prod_in;
      bias_ff      <= bias_in;
      inside_ff    <= inside_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataW-1){1'b0}}, inside_ff};

endmodule

FILE: rtl/fct_checker.sv
`include "frustum_cull_tester_core_macros.svh"

module fct_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [fct_pkg::RspDataW-1:0] rsp_tdata
);
   import fct_pkg::*;

   logic rsp_stall;

   assign rsp_stall = rsp_tvalid && !rsp_tready;

   `FCT_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_tvalid, "result dropped while stalled")
   `FCT_ASSERT_NXT(a_rsp_stable, rsp_stall, $stable(rsp_tdata), "result changed while stalled")
   // a ready result side keeps the whole pipeline moving
   `FCT_ASSERT_IMP(a_full_rate, rsp_tready, req_tready, "input stalled with result side ready")
   // first edge out of reset shows nothing
   `FCT_ASSERT_RST(a_reset_empty, $past(reset) && !reset, !rsp_tvalid, "result shown right after reset")

endmodule

bind frustum_cull_tester_core fct_checker u_fct_checker (.*);

FILE: tb/sv/tb_frustum_cull_tester_core.sv
module tb_frustum_cull_tester_core;
   timeunit 1ns;
   timeprecision 1ps;

   import fct_pkg::*;

   localparam int RandomItems = 950;
   localparam int NoFixed     = -1;
   localparam int SettleCycles = 20;
   localparam int NormalSpan  = 65536;
   localparam int PointSpan   = 4 * 65536;

   localparam coord_type One      = 32'sh0001_0000;
   localparam coord_type MinCoord = 32'sh8000_0000;
   localparam coord_type MaxCoord = 32'sh7FFF_FFFF;
   localparam coord_type Fill     = 32'sh5A5A_A5A5;

   typedef struct {
      func_type       func;
      logic [2:0]     plane;
      coord_type      cx, cy, cz;
      coord_type      fx, fy, fz;
      coord_type      scalar;
      int             fixed_res;
   } cull_req_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [ReqDataW-1:0]   req_tdata  = '0;
   logic [ReqUserW-1:0]   req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RspDataW-1:0]   rsp_tdata;

   coord_type plane_n [NumPlanes][NumAxes] = '{default: '0};
   coord_type plane_w [NumPlanes]          = '{default: '0};
   logic      pending_inside [$];
   int        n_errors   = 0;
   int        burst_left = 0;

   frustum_cull_tester_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("TEST FAILED");
      $finish;
   end

   // Exact Q32.32 sum per plane; the shape is culled when any sum goes negative.
   function automatic logic frustum_admits(cull_req_type it);
      logic signed [71:0] acc, nrm, near_p, far_p, rad;
      logic signed [71:0] lo_c [NumAxes];
      logic signed [71:0] hi_c [NumAxes];
      logic               ok;
      int                 i, k;
      lo_c[0] = 72'(it.cx);
      lo_c[1] = 72'(it.cy);
      lo_c[2] = 72'(it.cz);
      hi_c[0] = 72'(it.fx);
      hi_c[1] = 72'(it.fy);
      hi_c[2] = 72'(it.fz);
      rad = 72'(it.scalar);
      ok = 1'b1;
      for (i = 0; i < NumPlanes; i++) begin
         acc = 72'(plane_w[i]);
         acc = acc <<< FracW;
         for (k = 0; k < NumAxes; k++) begin
            nrm = 72'(plane_n[i][k]);
            near_p = nrm * lo_c[k];
            if (it.func == FUNC_BOX) begin
               // take the corner that lies furthest along the normal
               far_p = nrm * hi_c[k];
               if (far_p > near_p) near_p = far_p;
            end
            acc = acc + near_p;
         end
         if (it.func == FUNC_SPHERE) acc = acc + (rad <<< FracW);
         if (acc < 0) ok = 1'b0;
      end
      return ok;
   endfunction

   function automatic void record_transfer(cull_req_type it);
      if (it.func == FUNC_LOAD) begin
         // indexes past the last plane are dropped
         if (it.plane < NumPlanes) begin
            plane_n[it.plane][0] = it.cx;
            plane_n[it.plane][1] = it.cy;
            plane_n[it.plane][2] = it.cz;
            plane_w[it.plane]    = it.scalar;
         end
      end else if (it.fixed_res != NoFixed) begin
         pending_inside.push_back(it.fixed_res != 0);
      end else begin
         pending_inside.push_back(frustum_admits(it));
      end
   endfunction

   function automatic cull_req_type mk(func_type f, logic [2:0] p, coord_type cx,
                                       coord_type cy, coord_type cz, coord_type fx,
                                       coord_type fy, coord_type fz, coord_type s, int res);
      cull_req_type it;
      it.func = f;
      it.plane = p;
      it.cx = cx;
      it.cy = cy;
      it.cz = cz;
      it.fx = fx;
      it.fy = fy;
      it.fz = fz;
      it.scalar = s;
      it.fixed_res = res;
      return it;
   endfunction

   function automatic coord_type rand_coord(int span);
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 3) return $urandom;
      if (pick < 6) begin
         case ($urandom_range(0, 4))
            0: return MinCoord;
            1: return MaxCoord;
            2: return 0;
            3: return -1;
            default: return One;
         endcase
      end
      return $urandom_range(0, 2 * span) - span;
   endfunction

   function automatic cull_req_type random_item();
      cull_req_type it;
      int           roll;
      roll = $urandom_range(0, 99);
      it.plane = 3'($urandom_range(0, 7));
      it.cx = $urandom;
      it.cy = $urandom;
      it.cz = $urandom;
      it.fx = $urandom;
      it.fy = $urandom;
      it.fz = $urandom;
      it.scalar = $urandom;
      it.fixed_res = NoFixed;
      if (roll < 15) begin
         it.func = FUNC_LOAD;
         it.cx = rand_coord(NormalSpan);
         it.cy = rand_coord(NormalSpan);
         it.cz = rand_coord(NormalSpan);
         // mostly keep the origin inside so that tests pass often enough
         if ($urandom_range(0, 3) != 0) it.scalar = $urandom_range(0, 4 * 65536);
         else it.scalar = rand_coord(PointSpan);
      end else begin
         it.func = func_type'($urandom_range(1, 3));
         it.cx = rand_coord(PointSpan);
         it.cy = rand_coord(PointSpan);
         it.cz = rand_coord(PointSpan);
         if (it.func == FUNC_BOX && $urandom_range(0, 4) != 0) begin
            it.fx = it.cx + coord_type'($urandom_range(0, 2 * 65536));
            it.fy = it.cy + coord_type'($urandom_range(0, 2 * 65536));
            it.fz = it.cz + coord_type'($urandom_range(0, 2 * 65536));
         end else if (it.func == FUNC_BOX) begin
            it.fx = rand_coord(PointSpan);
            it.fy = rand_coord(PointSpan);
            it.fz = rand_coord(PointSpan);
         end
         if (it.func == FUNC_SPHERE) begin
            if ($urandom_range(0, 4) != 0) it.scalar = $urandom_range(0, 2 * 65536);
            else it.scalar = rand_coord(PointSpan);
         end
      end
      return it;
   endfunction

   // Open a gap at the start of a burst, except for about one burst in four.
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send_item(input cull_req_type it);
      req_tvalid <= 1'b1;
      req_tdata  <= {it.scalar, it.fz, it.fy, it.fx, it.cz, it.cy, it.cx};
      req_tuser  <= {it.plane, it.func};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      record_transfer(it);
   endtask

   // Hold off the sender until every pending result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_inside.size() != 0) @(posedge clock);
   endtask

   initial begin
      int mode, span;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(1, 30);
         repeat (span) begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= $urandom_range(0, 1);
               2: rsp_tready <= ($urandom_range(0, 3) != 0);
               default: rsp_tready <= (span > 12) ? ($urandom_range(0, 1) != 0) : 1'b0;
            endcase
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      logic want_inside;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_inside.size() == 0) begin
            $display("%0t: unexpected result transfer, expected none, got inside_res %0b",
                     $time, rsp_tdata[0]);
            n_errors++;
         end else begin
            want_inside = pending_inside.pop_front();
            if (rsp_tdata[0] !== want_inside) begin
               $display("%0t: inside_res mismatch, expected %0b, got %0b",
                        $time, want_inside, rsp_tdata[0]);
               n_errors++;
            end
         end
      end
   end

   initial begin
      cull_req_type rows [$];
      int           n;
      // empty planes pass everything except a sphere with negative radius
      rows.push_back(mk(FUNC_POINT, 3'd7, MinCoord, MinCoord, MinCoord, Fill, Fill, Fill,
                        Fill, 1));
      rows.push_back(mk(FUNC_POINT, 3'd0, MaxCoord, MaxCoord, MaxCoord, Fill, Fill, Fill,
                        Fill, 1));
      rows.push_back(mk(FUNC_SPHERE, 3'd2, MinCoord, MaxCoord, 0, Fill, Fill, Fill, 0, 1));
      rows.push_back(mk(FUNC_SPHERE, 3'd5, 0, 0, 0, Fill, Fill, Fill, -1, 0));
      rows.push_back(mk(FUNC_SPHERE, 3'd1, MaxCoord, MinCoord, MaxCoord, Fill, Fill, Fill,
                        MaxCoord, 1));
      rows.push_back(mk(FUNC_BOX, 3'd4, MaxCoord, MaxCoord, MaxCoord, MinCoord, MinCoord,
                        MinCoord, Fill, 1));
      // loads past the last plane leave the planes empty
      rows.push_back(mk(FUNC_LOAD, 3'd6, One, 0, 0, Fill, Fill, Fill, MinCoord, NoFixed));
      rows.push_back(mk(FUNC_LOAD, 3'd7, 0, One, 0, Fill, Fill, Fill, MinCoord, NoFixed));
      rows.push_back(mk(FUNC_POINT, 3'd0, -1, -1, -1, Fill, Fill, Fill, Fill, 1));
      // plane 0 keeps x >= 0
      rows.push_back(mk(FUNC_LOAD, 3'd0, One, 0, 0, Fill, Fill, Fill, 0, NoFixed));
      rows.push_back(mk(FUNC_POINT, 3'd3, -1, 0, 0, Fill, Fill, Fill, Fill, 0));
      rows.push_back(mk(FUNC_POINT, 3'd3, 0, MaxCoord, MinCoord, Fill, Fill, Fill, Fill, 1));
      rows.push_back(mk(FUNC_SPHERE, 3'd0, -2 * One, 0, 0, Fill, Fill, Fill, One, NoFixed));
      rows.push_back(mk(FUNC_SPHERE, 3'd0, -One, 0, 0, Fill, Fill, Fill, One, NoFixed));
      rows.push_back(mk(FUNC_BOX, 3'd0, -5 * One, 0, 0, -One, 0, 0, Fill, NoFixed));
      rows.push_back(mk(FUNC_BOX, 3'd0, 3 * One, 0, 0, -3 * One, 0, 0, Fill, NoFixed));
      rows.push_back(mk(FUNC_LOAD, 3'd5, MinCoord, MaxCoord, MinCoord, Fill, Fill, Fill,
                        MaxCoord, NoFixed));
      rows.push_back(mk(FUNC_LOAD, 3'd3, 0, -One, 0, Fill, Fill, Fill, 2 * One, NoFixed));
      rows.push_back(mk(FUNC_POINT, 3'd0, MaxCoord, MaxCoord, MaxCoord, Fill, Fill, Fill,
                        Fill, NoFixed));
      rows.push_back(mk(FUNC_POINT, 3'd0, MinCoord, MinCoord, MinCoord, Fill, Fill, Fill,
                        Fill, NoFixed));
      rows.push_back(mk(FUNC_SPHERE, 3'd0, MinCoord, MinCoord, MinCoord, Fill, Fill, Fill,
                        MaxCoord, NoFixed));
      rows.push_back(mk(FUNC_BOX, 3'd0, MinCoord, MinCoord, MinCoord, MaxCoord, MaxCoord,
                        MaxCoord, Fill, NoFixed));
      rows.push_back(mk(FUNC_BOX, 3'd0, 0, 0, MaxCoord, One, One, MinCoord, Fill, NoFixed));
      rows.push_back(mk(FUNC_POINT, 3'd0, 0, 2 * One, 0, Fill, Fill, Fill, Fill, NoFixed));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[r]) begin
         pace();
         send_item(rows[r]);
      end
      drain_results();

      for (n = 0; n < RandomItems; n++) begin
         if (n == RandomItems / 2) drain_results();
         pace();
         send_item(random_item());
      end
      drain_results();
      repeat (SettleCycles) @(posedge clock);

      if (n_errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/fct_pkg.sv
rtl/frustum_cull_tester_core.sv
rtl/fct_checker.sv
tb/sv/tb_frustum_cull_tester_core.sv
